FILE: hw/rtl/trp_pkg.sv
// Shared types and constants for the task run-time profiler.
// No dependencies; used by task_runtime_profiler.
`timescale 1ns / 1ps

package trp_pkg;

    localparam int OP_W   = 2;
    localparam int TIME_W = 32;
    localparam int TASK_W = 8;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 32;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_ENTER = 2'd0;
    localparam t_op OP_LEAVE = 2'd1;
    localparam t_op OP_READ  = 2'd2;

    localparam logic [TASK_W-1:0] TASK_IDLE = '0;
    localparam logic [TASK_W-1:0] HTI_RESET = 8'd32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CH_RD,
        S_CH_WR,
        S_CNT_RD,
        S_CNT_WR,
        S_FOLD_RD,
        S_FOLD_ACC,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

endpackage

FILE: hw/rtl/task_runtime_profiler.sv
// Per-task run-time profiler: slot store, dispatch charging and report walk.
// Depends on trp_pkg.
`timescale 1ns / 1ps

// Dispatch enter: accept, slot read, slot write. Dispatch leave to a task: the
// same, then a second read-modify-write counts the run. Read: accept, a read and
// accumulate per slot folded into entry 1, then a read, load and wait per report
// entry, stalled by the output. All paths share one single-port slot memory.
// Reset is synchronous; per-slot valid bits make the whole store read as zero
// right after reset, with no clearing pass.
module task_runtime_profiler #(
    parameter int OVERFLOW_SLOT = 32,
    parameter int REPORT_SLOTS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_data,     // highest_task_id
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [39:0]  i_s_tdata,      // time_req[31:0], new_task[39:32]
    input  logic [1:0]   i_s_tuser,      // operation[1:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,      // slot_index[3:0], run_count[35:4],
                                         // run_time[67:36], previous_read_time[99:68]
    output logic         o_m_tlast       // last
);

    localparam int NUM_SLOTS = OVERFLOW_SLOT + 1;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int TIME_W    = trp_pkg::TIME_W;
    localparam int CNT_W     = trp_pkg::CNT_W;
    localparam int TASK_W    = trp_pkg::TASK_W;
    localparam int IDX_W     = trp_pkg::IDX_W;
    localparam int MEM_W     = CNT_W + TIME_W;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [TASK_W-1:0] id);
        return (int'(id) < OVERFLOW_SLOT) ? SLOT_W'(id) : SLOT_W'(OVERFLOW_SLOT);
    endfunction

    trp_pkg::t_state r_state, n_state;

    logic [MEM_W-1:0]  r_mem [NUM_SLOTS];
    logic [MEM_W-1:0]  r_rdata;
    logic              r_rd_valid;
    logic [NUM_SLOTS-1:0] r_valid;

    logic              mem_we;
    logic [MEM_W-1:0]  mem_wdata;
    logic              clr_en;

    trp_pkg::t_op      r_op, n_op;
    logic [TIME_W-1:0] r_time, n_time;
    logic [TASK_W-1:0] r_task, n_task;
    logic [TASK_W-1:0] r_cur_task, n_cur_task;
    logic [TIME_W-1:0] r_stamp, n_stamp;
    logic [TIME_W-1:0] r_read_time, n_read_time;
    logic [TIME_W-1:0] r_prev, n_prev;
    logic [TASK_W-1:0] r_hti;
    logic [SLOT_W-1:0] r_addr, n_addr;
    logic [CNT_W-1:0]  r_acc_cnt, n_acc_cnt;
    logic [TIME_W-1:0] r_acc_time, n_acc_time;

    logic              r_out_valid, n_out_valid;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;
    logic [TIME_W-1:0] r_out_time, n_out_time;
    logic              r_out_last, n_out_last;

    logic [CNT_W-1:0]  eff_cnt;
    logic [TIME_W-1:0] eff_time;
    logic [SLOT_W-1:0] top_c;
    logic [SLOT_W-1:0] fin_c;
    logic              fold_c;

    assign eff_cnt  = r_rd_valid ? r_rdata[MEM_W-1:TIME_W] : '0;
    assign eff_time = r_rd_valid ? r_rdata[TIME_W-1:0] : '0;
    assign top_c    = (int'(r_hti) > OVERFLOW_SLOT) ? SLOT_W'(OVERFLOW_SLOT) : SLOT_W'(r_hti);
    assign fold_c   = (int'(top_c) >= REPORT_SLOTS);
    assign fin_c    = fold_c ? SLOT_W'(REPORT_SLOTS - 1) : top_c;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == trp_pkg::S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {4'b0, r_prev, r_out_time, r_out_cnt, r_out_idx};
    assign o_m_tlast   = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_time      = r_time;
        n_task      = r_task;
        n_cur_task  = r_cur_task;
        n_stamp     = r_stamp;
        n_read_time = r_read_time;
        n_prev      = r_prev;
        n_addr      = r_addr;
        n_acc_cnt   = r_acc_cnt;
        n_acc_time  = r_acc_time;
        n_out_valid = r_out_valid;
        n_out_idx   = r_out_idx;
        n_out_cnt   = r_out_cnt;
        n_out_time  = r_out_time;
        n_out_last  = r_out_last;
        mem_we      = 1'b0;
        mem_wdata   = {eff_cnt, eff_time};
        clr_en      = 1'b0;
        unique case (r_state)
            trp_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op   = i_s_tuser;
                    n_time = i_s_tdata[TIME_W-1:0];
                    n_task = i_s_tdata[TIME_W+TASK_W-1:TIME_W];
                    case (i_s_tuser) inside
                        trp_pkg::OP_ENTER, trp_pkg::OP_LEAVE: begin
                            n_addr  = slot_of(r_cur_task);
                            n_state = trp_pkg::S_CH_RD;
                        end
                        trp_pkg::OP_READ: begin
                            n_prev      = r_read_time;
                            n_read_time = i_s_tdata[TIME_W-1:0];
                            n_acc_cnt   = '0;
                            n_acc_time  = '0;
                            if (fold_c) begin
                                n_addr  = SLOT_W'(REPORT_SLOTS);
                                n_state = trp_pkg::S_FOLD_RD;
                            end else begin
                                n_addr  = '0;
                                n_state = trp_pkg::S_EMIT_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            trp_pkg::S_CH_RD: begin
                n_state = trp_pkg::S_CH_WR;
            end
            trp_pkg::S_CH_WR: begin
                mem_we    = 1'b1;
                mem_wdata = {eff_cnt, eff_time + (r_time - r_stamp)};
                n_stamp   = r_time;
                n_state   = trp_pkg::S_IDLE;
                if (r_op == trp_pkg::OP_LEAVE) begin
                    n_cur_task = r_task;
                    if (r_task != trp_pkg::TASK_IDLE) begin
                        n_addr  = slot_of(r_task);
                        n_state = trp_pkg::S_CNT_RD;
                    end
                end else if (r_task == trp_pkg::TASK_IDLE) begin
                    n_cur_task = trp_pkg::TASK_IDLE;
                end
            end
            trp_pkg::S_CNT_RD: begin
                n_state = trp_pkg::S_CNT_WR;
            end
            trp_pkg::S_CNT_WR: begin
                mem_we    = 1'b1;
                mem_wdata = {eff_cnt + CNT_W'(1), eff_time};
                n_state   = trp_pkg::S_IDLE;
            end
            trp_pkg::S_FOLD_RD: begin
                n_state = trp_pkg::S_FOLD_ACC;
            end
            trp_pkg::S_FOLD_ACC: begin
                clr_en     = 1'b1;
                n_acc_cnt  = r_acc_cnt + eff_cnt;
                n_acc_time = r_acc_time + eff_time;
                if (r_addr == top_c) begin
                    n_addr  = '0;
                    n_state = trp_pkg::S_EMIT_RD;
                end else begin
                    n_addr  = r_addr + SLOT_W'(1);
                    n_state = trp_pkg::S_FOLD_RD;
                end
            end
            trp_pkg::S_EMIT_RD: begin
                n_state = trp_pkg::S_EMIT_LD;
            end
            trp_pkg::S_EMIT_LD: begin
                clr_en      = 1'b1;
                n_out_valid = 1'b1;
                n_out_idx   = IDX_W'(r_addr);
                n_out_cnt   = eff_cnt + ((r_addr == SLOT_W'(1)) ? r_acc_cnt : '0);
                n_out_time  = eff_time + ((r_addr == SLOT_W'(1)) ? r_acc_time : '0);
                n_out_last  = (r_addr == fin_c);
                n_state     = trp_pkg::S_EMIT_WAIT;
            end
            trp_pkg::S_EMIT_WAIT: begin
                if (i_m_tready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = trp_pkg::S_IDLE;
                    end else begin
                        n_addr  = r_addr + SLOT_W'(1);
                        n_state = trp_pkg::S_EMIT_RD;
                    end
                end
            end
            default: n_state = trp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_task  <= trp_pkg::TASK_IDLE;
            r_stamp     <= '0;
            r_read_time <= '0;
            r_hti       <= trp_pkg::HTI_RESET;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_cur_task  <= n_cur_task;
            r_stamp     <= n_stamp;
            r_read_time <= n_read_time;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_hti <= i_cfg_data;
            end
            if (mem_we) begin
                r_valid[r_addr] <= 1'b1;
            end else if (clr_en) begin
                r_valid[r_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_time     <= n_time;
        r_task     <= n_task;
        r_prev     <= n_prev;
        r_addr     <= n_addr;
        r_acc_cnt  <= n_acc_cnt;
        r_acc_time <= n_acc_time;
        r_out_idx  <= n_out_idx;
        r_out_cnt  <= n_out_cnt;
        r_out_time <= n_out_time;
        r_out_last <= n_out_last;
        r_rd_valid <= r_valid[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

endmodule
